FILE: rtl/ptso_pkg.sv
// shared widths, codes and helpers for the point to segment offset block
package ptso_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_END_X   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_END_Y   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_END_Z   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_INF     = 3'd6;

    // derived widths
    localparam int DW   = COORD_WIDTH + 1;          // difference vectors
    localparam int PW   = 2 * DW;                   // one product
    localparam int NW   = PW + 2;                   // dot product (signed)
    localparam int DENW = 2 * COORD_WIDTH + 2;      // squared length
    localparam int NUMW = NW + FRAC_BITS + 1;       // scaled dividend
    localparam int QB   = COORD_WIDTH - 1;          // quotient bits
    localparam int XW   = NUMW + COORD_WIDTH;       // overflow compare
    localparam int MW   = COORD_WIDTH + DW;         // t * d
    localparam int OW   = MW + 2;                   // offset before rounding

    // parameter selection codes
    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] T_ONE = (FRAC_BITS < COORD_WIDTH - 1) ?
        (COORD_WIDTH'(1) << FRAC_BITS) : C_MAX;

    // control carried through the divider
    typedef struct packed {
        logic [2:0][DW-1:0] w;
        logic               neg;
        logic [1:0]         mode;
        logic               degen;
        logic               ovf;
    } div_ctl_t;

endpackage

FILE: rtl/point_to_segment_offset_top.sv
// point to line segment offset: fully pipelined top level
// throughput: one request per cycle unless the result side stalls;
// the restoring divider has one stage per quotient bit
// a stall on the result side holds the whole pipeline, nothing is dropped
// reset: synchronous active-low aresetn clears all valid bits and loads the
// default line from the origin to (1.0, 0, 0) in clamped mode
module point_to_segment_offset_top
    import ptso_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IW-1:0]          cfg_index,
    input  logic [COORD_WIDTH-1:0]     cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [3*COORD_WIDTH-1:0]   s_tdata,   // point_x, point_y, point_z
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [4*COORD_WIDTH-1:0]   m_tdata,   // offset_x, offset_y, offset_z, line_param
    output logic [0:0]                 m_tuser    // degenerate
);

    // configuration registers
    logic [2:0][COORD_WIDTH-1:0] start_reg;
    logic [2:0][COORD_WIDTH-1:0] end_reg;
    logic                        inf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            end_reg[2] <= '0;
            end_reg[1] <= '0;
            end_reg[0] <= COORD_WIDTH'(1) << FRAC_BITS;
            inf_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_X: start_reg[0] <= cfg_wdata;
                REG_START_Y: start_reg[1] <= cfg_wdata;
                REG_START_Z: start_reg[2] <= cfg_wdata;
                REG_END_X:   end_reg[0]   <= cfg_wdata;
                REG_END_Y:   end_reg[1]   <= cfg_wdata;
                REG_END_Z:   end_reg[2]   <= cfg_wdata;
                REG_INF:     inf_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // line direction and squared length, derived from configuration
    logic [2:0][DW-1:0]   d_reg;
    logic [2:0][DENW-1:0] sq_reg;
    logic [DENW-1:0]      den_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            d_reg[i]  <= DW'($signed(end_reg[i])) - DW'($signed(start_reg[i]));
            sq_reg[i] <= $signed(d_reg[i]) * $signed(d_reg[i]);
        end
        den_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    logic adv;
    logic v8_reg;
    assign adv      = !v8_reg || m_tready;
    assign s_tready = adv;

    // stage 1: w = p - s
    logic               v1_reg;
    logic [2:0][DW-1:0] w1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            for (int i = 0; i < 3; i++)
                w1_reg[i] <= DW'($signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]))
                           - DW'($signed(start_reg[i]));
        end
    end

    // stage 2: w_i * d_i
    logic               v2_reg;
    logic [2:0][DW-1:0] w2_reg;
    logic [2:0][PW-1:0] pr2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            w2_reg <= w1_reg;
            for (int i = 0; i < 3; i++)
                pr2_reg[i] <= $signed(w1_reg[i]) * $signed(d_reg[i]);
        end
    end

    // stage 3: dot product
    logic               v3_reg;
    logic [2:0][DW-1:0] w3_reg;
    logic [NW-1:0]      num3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            w3_reg   <= w2_reg;
            num3_reg <= NW'($signed(pr2_reg[0])) + NW'($signed(pr2_reg[1]))
                      + NW'($signed(pr2_reg[2]));
        end
    end

    // stage 4: classify and build the rounded dividend
    logic [NW-1:0]  mag3;
    logic           neg3;
    logic [1:0]     mode3;
    logic           degen3;
    always_comb begin
        neg3   = num3_reg[NW-1];
        mag3   = neg3 ? (NW'(0) - num3_reg) : num3_reg;
        degen3 = (den_reg == '0);
        if (degen3)
            mode3 = MODE_ZERO;
        else if (!inf_reg && (neg3 || num3_reg == '0))
            mode3 = MODE_ZERO;
        else if (!inf_reg && (mag3 >= NW'(den_reg)))
            mode3 = MODE_ONE;
        else
            mode3 = MODE_DIV;
    end

    logic               v4_reg;
    logic [2:0][DW-1:0] w4_reg;
    logic [NUMW-1:0]    n4_reg;
    logic               neg4_reg;
    logic [1:0]         mode4_reg;
    logic               degen4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            w4_reg     <= w3_reg;
            n4_reg     <= (NUMW'(mag3) << FRAC_BITS) + NUMW'(den_reg >> 1);
            neg4_reg   <= neg3;
            mode4_reg  <= mode3;
            degen4_reg <= degen3;
        end
    end

    // divider: entry stage checks overflow, then one stage per quotient bit
    logic             dv_reg  [QB+1];
    div_ctl_t         dc_reg  [QB+1];
    logic [DENW-1:0]  rem_reg [QB+1];
    logic [QB-1:0]    nb_reg  [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];

    logic ovf4;
    assign ovf4 = XW'(n4_reg) >= (XW'(den_reg) << (COORD_WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_reg[0] <= 1'b0;
        else if (adv) dv_reg[0] <= v4_reg;
        if (adv) begin
            dc_reg[0].w     <= w4_reg;
            dc_reg[0].neg   <= neg4_reg;
            dc_reg[0].mode  <= mode4_reg;
            dc_reg[0].degen <= degen4_reg;
            dc_reg[0].ovf   <= ovf4;
            rem_reg[0]      <= DENW'(n4_reg >> QB);
            nb_reg[0]       <= n4_reg[QB-1:0];
            q_reg[0]        <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [DENW:0] trial;
        logic          ge;
        assign trial = {rem_reg[k], nb_reg[k][QB-1]};
        assign ge    = trial >= {1'b0, den_reg};

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_reg[k+1] <= 1'b0;
            else if (adv) dv_reg[k+1] <= dv_reg[k];
            if (adv) begin
                dc_reg[k+1]  <= dc_reg[k];
                rem_reg[k+1] <= ge ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
                nb_reg[k+1]  <= nb_reg[k] << 1;
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
            end
        end
    end

    // stage 6: sign, saturation and selection of t
    div_ctl_t               dcq;
    logic [COORD_WIDTH-1:0] t5;
    assign dcq = dc_reg[QB];
    always_comb begin
        case (dcq.mode)
            MODE_ZERO: t5 = '0;
            MODE_ONE:  t5 = T_ONE;
            MODE_DIV: begin
                if (dcq.ovf)
                    t5 = dcq.neg ? C_MIN : C_MAX;
                else if (dcq.neg)
                    t5 = COORD_WIDTH'(0) - COORD_WIDTH'(q_reg[QB]);
                else
                    t5 = COORD_WIDTH'(q_reg[QB]);
            end
            default:   t5 = '0;
        endcase
    end

    logic                   v6_reg;
    logic [2:0][DW-1:0]     w6_reg;
    logic [COORD_WIDTH-1:0] t6_reg;
    logic                   degen6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= dv_reg[QB];
        if (adv) begin
            w6_reg     <= dcq.w;
            t6_reg     <= t5;
            degen6_reg <= dcq.degen;
        end
    end

    // stage 7: t * d_i
    logic                   v7_reg;
    logic [2:0][DW-1:0]     w7_reg;
    logic [2:0][MW-1:0]     m7_reg;
    logic [COORD_WIDTH-1:0] t7_reg;
    logic                   degen7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
        if (adv) begin
            w7_reg     <= w6_reg;
            t7_reg     <= t6_reg;
            degen7_reg <= degen6_reg;
            for (int i = 0; i < 3; i++)
                m7_reg[i] <= $signed(t6_reg) * $signed(d_reg[i]);
        end
    end

    // stage 8: subtract scaled w, round, saturate
    logic [2:0][COORD_WIDTH-1:0] off7;
    always_comb begin
        logic signed [OW-1:0] val;
        logic signed [OW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            val = OW'($signed(m7_reg[i])) - (OW'($signed(w7_reg[i])) <<< FRAC_BITS)
                + (OW'(1) <<< (FRAC_BITS - 1));
            sh  = val >>> FRAC_BITS;
            if ((&sh[OW-1:COORD_WIDTH-1]) || !(|sh[OW-1:COORD_WIDTH-1]))
                off7[i] = sh[COORD_WIDTH-1:0];
            else
                off7[i] = sh[OW-1] ? C_MIN : C_MAX;
        end
    end

    logic [4*COORD_WIDTH-1:0] data8_reg;
    logic                     degen8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v7_reg;
        if (adv) begin
            data8_reg  <= {t7_reg, off7[2], off7[1], off7[0]};
            degen8_reg <= degen7_reg;
        end
    end

    assign m_tvalid   = v8_reg;
    assign m_tdata    = data8_reg;
    assign m_tuser[0] = degen8_reg;

endmodule

FILE: rtl/ptso_checker.sv
// port-level checks for the point to segment offset block, with bind
module ptso_props
    import ptso_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [4*COORD_WIDTH-1:0] m_tdata,
    input logic [0:0]               m_tuser
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a zero-length line always reports t of zero
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH] == '0)
        else $error("degenerate line with nonzero t");

    // a held result stalls the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while pipeline stalled");

endmodule

bind point_to_segment_offset_top ptso_props u_ptso_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
